@@ sv/bitmap_frame_allocator_defines.svh @@
// assertion macros for the bitmap frame allocator
// used by the top level only, expects clk and rst_n in scope
`ifndef BITMAP_FRAME_ALLOCATOR_DEFINES_SVH
`define BITMAP_FRAME_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define BFA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bitmap_frame_allocator: check failed");
`define BFA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bitmap_frame_allocator: check failed");
`else
`define BFA_ASSERT_IMP(lbl, ante, cons)
`define BFA_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ sv/bfa_pkg.sv @@
// shared types and constants of the bitmap frame allocator
// no dependencies
`timescale 1ns / 1ps

package bfa_pkg;

  localparam int WORD_BITS = 32;
  localparam int WORD_SH   = 5;
  localparam int FRAME_W   = 14;
  localparam int FIU_W     = 15;

  localparam logic [FIU_W-1:0] FIU_RESET = 15'd16384;

  // register index taken from the byte address
  localparam logic REG_FRAMES_IN_USE = 1'b0;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOTHING = 2'd1;
  localparam logic [1:0] ST_NOFREE  = 2'd2;

  typedef enum logic [1:0] {
    RK_NOTHING,
    RK_NOFREE,
    RK_FREED,
    RK_ALLOC
  } res_kind_t;

  typedef struct packed {
    logic      clr;
    logic      load;
    logic      scan;
    logic      rd_free;
    logic      mark;
    logic      unmark;
    logic      post;
    res_kind_t kind;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_free;
    logic pf_zero;
    logic in_range;
    logic hit;
    logic scan_empty;
    logic out_open;
  } dp_sts_t;

endpackage

@@ sv/bfa_ctrl.sv @@
// control state machine of the bitmap frame allocator
// depends on bfa_pkg; drives the datapath through dp_cmd_t
`timescale 1ns / 1ps

module bfa_ctrl
  import bfa_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_FREE_WR,
    S_POST
  } state_t;

  state_t    state_r, state_nxt;
  res_kind_t kind_r, kind_nxt;
  logic      in_stall_r;

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    cmd       = '0;
    cmd.kind  = kind_r;
    case (state_r)
      S_INIT: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.pf_zero && !sts.is_free) begin
          state_nxt = S_SCAN;
        end else if (!sts.is_free || sts.pf_zero) begin
          kind_nxt  = RK_NOTHING;
          state_nxt = S_POST;
        end else if (sts.in_range) begin
          cmd.rd_free = 1'b1;
          state_nxt   = S_FREE_WR;
        end else begin
          // out-of-range frame: nothing to clear, still reported as done
          kind_nxt  = RK_FREED;
          state_nxt = S_POST;
        end
      end
      S_SCAN: begin
        if (sts.hit) begin
          cmd.mark  = 1'b1;
          kind_nxt  = RK_ALLOC;
          state_nxt = S_POST;
        end else if (sts.scan_empty) begin
          kind_nxt  = RK_NOFREE;
          state_nxt = S_POST;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_FREE_WR: begin
        cmd.unmark = 1'b1;
        kind_nxt   = RK_FREED;
        state_nxt  = S_POST;
      end
      S_POST: begin
        if (sts.out_open) begin
          cmd.post  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_INIT;
      kind_r     <= RK_NOTHING;
      in_stall_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      kind_r     <= kind_nxt;
      in_stall_r <= (state_nxt != S_IDLE);
    end
  end

  assign in_stall = in_stall_r;

endmodule

@@ sv/bfa_dp.sv @@
// datapath of the bitmap frame allocator: bitmap memory, scan pointer,
// item and result registers; depends on bfa_pkg
`timescale 1ns / 1ps

module bfa_dp
  import bfa_pkg::*;
#(
  parameter int MAX_FRAMES = 16384
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts,
  input  logic [FIU_W-1:0]   frames_in_use,
  input  logic               in_action,
  input  logic [FRAME_W-1:0] in_page_frame,
  input  logic               in_is_kernel,
  input  logic               in_is_writeable,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [FRAME_W-1:0] out_frame,
  output logic               out_present,
  output logic               out_writable,
  output logic               out_user_mode,
  output logic [1:0]         out_status
);

  localparam int NUM_WORDS = MAX_FRAMES / WORD_BITS;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int CNT_W     = $clog2(NUM_WORDS + 1);
  localparam int PW        = (AW + WORD_SH > FRAME_W) ? AW + WORD_SH : FRAME_W;

  logic [WORD_BITS-1:0] bitmap_mem [NUM_WORDS];

  logic [CNT_W-1:0]     ptr_r, ptr_nxt;
  logic [AW-1:0]        rd_addr_r;
  logic [WORD_BITS-1:0] rd_data_r;
  logic                 rd_vld_r;

  logic                 act_r, kern_r, wrt_r;
  logic [FRAME_W-1:0]   pf_r;
  logic [FRAME_W-1:0]   alloc_frame_r;

  logic                 out_valid_r;
  logic [FRAME_W-1:0]   out_frame_r;
  logic                 out_present_r, out_writable_r, out_user_r;
  logic [1:0]           out_status_r;

  logic [CNT_W-1:0]     limit;
  logic [FIU_W-WORD_SH-1:0] fiu_words;
  logic                 more;
  logic [PW-1:0]        pf_ext, found_ext;
  logic [AW-1:0]        free_idx, raddr, waddr;
  logic [WORD_SH-1:0]   zbit;
  logic                 we;
  logic [WORD_BITS-1:0] wdata;

  // whole words only, saturated at the bitmap size
  assign fiu_words = frames_in_use[FIU_W-1:WORD_SH];
  assign limit = (32'(fiu_words) > 32'(NUM_WORDS)) ? CNT_W'(NUM_WORDS) : CNT_W'(fiu_words);
  assign more  = (ptr_r < limit);

  assign pf_ext   = PW'(pf_r);
  assign free_idx = pf_ext[AW+WORD_SH-1:WORD_SH];

  // lowest clear bit of the fetched word
  always_comb begin
    zbit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!rd_data_r[i]) zbit = WORD_SH'(i);
    end
  end

  assign found_ext = PW'({rd_addr_r, zbit});

  assign raddr = cmd.rd_free ? free_idx : ptr_r[AW-1:0];
  assign we    = cmd.clr | cmd.mark | cmd.unmark;

  always_comb begin
    if (cmd.clr) begin
      waddr = ptr_r[AW-1:0];
      wdata = '0;
    end else if (cmd.mark) begin
      waddr = rd_addr_r;
      wdata = rd_data_r | (WORD_BITS'(1) << zbit);
    end else begin
      waddr = free_idx;
      wdata = rd_data_r & ~(WORD_BITS'(1) << pf_r[WORD_SH-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (we) bitmap_mem[waddr] <= wdata;
    rd_data_r <= bitmap_mem[raddr];
    rd_addr_r <= raddr;
  end

  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.load) begin
      ptr_nxt = '0;
    end else if (cmd.clr || (cmd.scan && more)) begin
      ptr_nxt = ptr_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ptr_r    <= ptr_nxt;
      rd_vld_r <= cmd.scan && more;
      if (cmd.post) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= in_action;
      pf_r   <= in_page_frame;
      kern_r <= in_is_kernel;
      wrt_r  <= in_is_writeable;
    end
    // found frame is held apart so a stalled result is left intact
    if (cmd.mark) begin
      alloc_frame_r <= found_ext[FRAME_W-1:0];
    end
    if (cmd.post) begin
      out_present_r  <= 1'b0;
      out_writable_r <= 1'b0;
      out_user_r     <= 1'b0;
      case (cmd.kind)
        RK_NOTHING: begin
          out_frame_r  <= act_r ? '0 : pf_r;
          out_status_r <= ST_NOTHING;
        end
        RK_NOFREE: begin
          out_frame_r  <= '0;
          out_status_r <= ST_NOFREE;
        end
        RK_FREED: begin
          out_frame_r  <= '0;
          out_status_r <= ST_DONE;
        end
        RK_ALLOC: begin
          out_frame_r    <= alloc_frame_r;
          out_present_r  <= 1'b1;
          out_writable_r <= wrt_r;
          out_user_r     <= ~kern_r;
          out_status_r   <= ST_DONE;
        end
        default: out_status_r <= ST_DONE;
      endcase
    end
  end

  always_comb begin
    sts.clr_last   = (ptr_r == CNT_W'(NUM_WORDS - 1));
    sts.is_free    = act_r;
    sts.pf_zero    = (pf_r == '0);
    sts.in_range   = (32'(pf_r) < 32'(MAX_FRAMES)) &&
                     (32'(pf_r[FRAME_W-1:WORD_SH]) < 32'(NUM_WORDS));
    sts.hit        = rd_vld_r && (rd_data_r != '1);
    sts.scan_empty = !rd_vld_r && !more;
    sts.out_open   = !out_valid_r || !out_stall;
  end

  assign out_valid     = out_valid_r;
  assign out_frame     = out_frame_r;
  assign out_present   = out_present_r;
  assign out_writable  = out_writable_r;
  assign out_user_mode = out_user_r;
  assign out_status    = out_status_r;

endmodule

@@ sv/bitmap_frame_allocator.sv @@
// Bitmap frame allocator: one used/free bit per physical frame, kept in a
// single-port-write, registered-read memory of 32-bit words. After reset the
// block runs a clearing pass over the MAX_FRAMES/32 words (512 by default) with
// in_stall high; configuration writes are taken meanwhile. It then works on
// one item at a time. A free of a frame in range reads its bitmap word and
// writes it back with the bit cleared; an allocate for a page that already holds
// a frame or a free of frame zero is answered with no work done; an allocate
// that searches reads words up to and including the first one with a clear bit,
// or all W words when there is no free frame, W being frames_in_use/32 capped
// at the bitmap size: the search reads one memory word per cycle. A finished
// result waits in an output register, so the next item can be taken while it
// is still stalled; a result still stalled when the next one is ready holds it back.
// depends on bfa_pkg, bfa_ctrl, bfa_dp and bitmap_frame_allocator_defines.svh
`timescale 1ns / 1ps
`include "bitmap_frame_allocator_defines.svh"

module bitmap_frame_allocator
  import bfa_pkg::*;
#(
  parameter int MAX_FRAMES = 16384
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_action,
  input  logic [FRAME_W-1:0] in_page_frame,
  input  logic               in_is_kernel,
  input  logic               in_is_writeable,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [FRAME_W-1:0] out_frame,
  output logic               out_present,
  output logic               out_writable,
  output logic               out_user_mode,
  output logic [1:0]         out_status
);

  logic [FIU_W-1:0] fiu_r;
  logic             reg_sel;
  dp_cmd_t          cmd;
  dp_sts_t          sts;

  assign reg_sel = (paddr[2] == REG_FRAMES_IN_USE);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? 32'(fiu_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fiu_r <= FIU_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      fiu_r <= pwdata[FIU_W-1:0];
    end
  end

  bfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bfa_dp #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .frames_in_use   (fiu_r),
    .in_action       (in_action),
    .in_page_frame   (in_page_frame),
    .in_is_kernel    (in_is_kernel),
    .in_is_writeable (in_is_writeable),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_frame       (out_frame),
    .out_present     (out_present),
    .out_writable    (out_writable),
    .out_user_mode   (out_user_mode),
    .out_status      (out_status)
  );

  // a new result never overwrites one that is still stalled
  `BFA_ASSERT_IMP(a_post_slot_free, cmd.post, !(out_valid && out_stall))
  // the block is busy right after taking an item
  `BFA_ASSERT_NXT(a_busy_after_transfer, in_valid && !in_stall, in_stall)
  // only a successful allocation carries the present bit
  `BFA_ASSERT_IMP(a_present_is_done, out_valid && out_present, out_status == ST_DONE)

endmodule

@@ bench/tb_top.sv @@
// self-checking bench for bitmap_frame_allocator: directed page-entry cases, then
// random alloc/free traffic across several frames_in_use settings and stall mixes
// depends on bfa_pkg and the bitmap_frame_allocator rtl
`timescale 1ns / 1ps

module tb_top
  import bfa_pkg::*;
();

  localparam int          MAP_WORDS   = 16384 / WORD_BITS;
  localparam int          CYCLE_LIMIT = 4_000_000;
  localparam int          PHASE_ITEMS = 100;
  localparam logic        ACT_ALLOC   = 1'b0;
  localparam logic        ACT_FREE    = 1'b1;
  localparam logic [2:0]  FIU_ADDR    = {REG_FRAMES_IN_USE, 2'b00};

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               present;
    logic               writable;
    logic               user_mode;
    logic [1:0]         status;
  } page_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_action = 1'b0;
  logic [FRAME_W-1:0] in_page_frame = '0;
  logic               in_is_kernel = 1'b0;
  logic               in_is_writeable = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [FRAME_W-1:0] out_frame;
  logic               out_present;
  logic               out_writable;
  logic               out_user_mode;
  logic [1:0]         out_status;

  // predictor state
  logic [WORD_BITS-1:0] used_map [MAP_WORDS];
  logic [FIU_W-1:0]     frame_limit = FIU_RESET;
  page_result_t         expected_results [$];
  logic [FRAME_W-1:0]   held_frames [$];

  int mismatches = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  bitmap_frame_allocator DUT (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_page_frame(in_page_frame), .in_is_kernel(in_is_kernel),
    .in_is_writeable(in_is_writeable),
    .out_valid(out_valid), .out_stall(out_stall), .out_frame(out_frame),
    .out_present(out_present), .out_writable(out_writable),
    .out_user_mode(out_user_mode), .out_status(out_status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall = ($urandom_range(0, 99) < recv_stall_pct);
  end

  function automatic page_result_t predict_page_op(input logic act,
                                                   input logic [FRAME_W-1:0] pf,
                                                   input logic kern,
                                                   input logic wr);
    page_result_t r;
    int words;
    bit found;
    r = '0;
    r.status = ST_DONE;
    if (act == ACT_ALLOC) begin
      if (pf != 0) begin
        r.frame = pf;
        r.status = ST_NOTHING;
      end else begin
        // only whole words below the limit are searched, capped at the bitmap
        words = frame_limit / WORD_BITS;
        if (words > MAP_WORDS) words = MAP_WORDS;
        found = 1'b0;
        for (int w = 0; w < words && !found; w++) begin
          for (int b = 0; b < WORD_BITS && !found; b++) begin
            if (!used_map[w][b]) begin
              found = 1'b1;
              used_map[w][b] = 1'b1;
              r.frame = FRAME_W'(w * WORD_BITS + b);
              r.present = 1'b1;
              r.writable = wr;
              r.user_mode = ~kern;
            end
          end
        end
        if (!found) r.status = ST_NOFREE;
      end
    end else if (pf == 0) begin
      r.status = ST_NOTHING;
    end else begin
      used_map[pf / WORD_BITS][pf % WORD_BITS] = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input page_result_t exp_r,
                                 input page_result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $write("%0t %s: expected frame=%0d present=%0d writable=%0d user=%0d status=%0d",
             $realtime, what, exp_r.frame, exp_r.present, exp_r.writable,
             exp_r.user_mode, exp_r.status);
      $display(", got frame=%0d present=%0d writable=%0d user=%0d status=%0d",
               got.frame, got.present, got.writable, got.user_mode, got.status);
    end
  endtask

  // result checker: each result transfer is matched against the oldest prediction
  always @(posedge clk) begin
    page_result_t got;
    page_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      got.frame = out_frame;
      got.present = out_present;
      got.writable = out_writable;
      got.user_mode = out_user_mode;
      got.status = out_status;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", '0, got);
      end else begin
        exp_r = expected_results.pop_front();
        if (got !== exp_r) report_mismatch("result mismatch", exp_r, got);
      end
    end
  end

  // called and returns at a falling edge; valid stays high for back-to-back items
  task automatic send_page_op(input logic act, input logic [FRAME_W-1:0] pf,
                              input logic kern, input logic wr,
                              output page_result_t res);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_action = act;
    in_page_frame = pf;
    in_is_kernel = kern;
    in_is_writeable = wr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = predict_page_op(act, pf, kern, wr);
    expected_results.push_back(res);
    if (res.present) held_frames.push_back(res.frame);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_frame_limit(input logic [FIU_W-1:0] value);
    wait_drained();
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = FIU_ADDR;
    pwdata = 32'(value);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    frame_limit = value;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic alloc_page(input logic kern, input logic wr);
    page_result_t res;
    send_page_op(ACT_ALLOC, '0, kern, wr, res);
  endtask

  task automatic send_raw(input logic act, input logic [FRAME_W-1:0] pf);
    page_result_t res;
    send_page_op(act, pf, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), res);
  endtask

  // first allocations after reset, frame zero included, every kernel/write combination
  task automatic test_page_entry_bits();
    alloc_page(1'b0, 1'b0);
    alloc_page(1'b1, 1'b1);
    alloc_page(1'b0, 1'b1);
    alloc_page(1'b1, 1'b0);
  endtask

  task automatic test_nothing_to_do();
    send_raw(ACT_ALLOC, 14'd16383);
    send_raw(ACT_ALLOC, 14'd1);
    send_raw(ACT_FREE, '0);
  endtask

  task automatic test_free_paths();
    send_raw(ACT_FREE, 14'd2);
    alloc_page(1'b1, 1'b1);
    send_raw(ACT_FREE, 14'd16383);
    send_raw(ACT_FREE, 14'd5461);
  endtask

  // search window edges: no whole word, zero, saturated, one word
  task automatic test_search_limits();
    write_frame_limit(15'd31);
    alloc_page(1'b0, 1'b1);
    send_raw(ACT_FREE, 14'd3);
    alloc_page(1'b0, 1'b1);
    write_frame_limit(15'd0);
    alloc_page(1'b1, 1'b0);
    write_frame_limit(15'd32767);
    alloc_page(1'b0, 1'b0);
    write_frame_limit(15'd32);
    // frame beyond the managed range is still cleared
    send_raw(ACT_FREE, 14'd9000);
    alloc_page(1'b1, 1'b1);
  endtask

  task automatic run_traffic_phase(input logic [FIU_W-1:0] limit, input int idle_pct,
                                   input int stall_pct);
    page_result_t res;
    bit filling;
    int pick;
    int idx;
    write_frame_limit(limit);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    // small windows start by allocating until the search comes up empty
    filling = (limit <= 15'd160);
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (i == PHASE_ITEMS / 2) wait_drained();
      pick = $urandom_range(0, 99);
      if (filling || pick < 55 || (pick < 85 && held_frames.size() == 0)) begin
        send_page_op(ACT_ALLOC, '0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     res);
        if (res.status == ST_NOFREE) filling = 1'b0;
      end else if (pick < 85) begin
        idx = $urandom_range(0, held_frames.size() - 1);
        send_raw(ACT_FREE, held_frames[idx]);
        held_frames.delete(idx);
      end else if (pick < 90) begin
        send_raw(ACT_ALLOC, FRAME_W'($urandom_range(1, 16383)));
      end else if (pick < 95) begin
        send_raw(ACT_FREE, FRAME_W'($urandom_range(0, 16383)));
      end else begin
        send_raw(ACT_FREE, '0);
      end
    end
  endtask

  initial begin
    for (int w = 0; w < MAP_WORDS; w++) used_map[w] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_page_entry_bits();
    test_nothing_to_do();
    test_free_paths();
    test_search_limits();

    run_traffic_phase(15'd64, 0, 0);
    run_traffic_phase(15'd100, 71, 0);
    run_traffic_phase(15'd32, 0, 71);
    run_traffic_phase(15'd16384, 36, 36);
    run_traffic_phase(15'd96, 0, 0);
    run_traffic_phase(15'd32767, 71, 0);
    run_traffic_phase(15'd160, 0, 71);
    run_traffic_phase(15'd16384, 36, 36);

    wait_drained();
    recv_stall_pct = 0;
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/bfa_pkg.sv
sv/bfa_ctrl.sv
sv/bfa_dp.sv
sv/bitmap_frame_allocator.sv
bench/tb_top.sv
